// File: rtl/ordered_array_list_assert.svh
// Assertion macros for the ordered array list checks.
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_array_list: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_array_list: next-cycle check failed");

`endif

// File: rtl/oal_pkg.sv
// Shared types and codes for the ordered array list.
`timescale 1ns / 1ps

package oal_pkg;

  localparam int ACT_W  = 3;
  localparam int SLOT_W = 5;
  localparam int ID_W   = 32;
  localparam int NAME_W = 64;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 5;
  localparam int ENT_W  = ID_W + NAME_W;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_AT    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_AT    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_FIND      = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    CLS_INS,
    CLS_DEL,
    CLS_FIND,
    CLS_NONE
  } op_class_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_req;
    logic save_err;
    logic init_ins;
    logic init_del;
    logic init_scan;
    logic ins_step;
    logic del_step;
    logic scan_step;
    logic put_new;
    logic dec_count;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_class_t cls;
    logic      err;
    logic      ins_done;
    logic      del_done;
    logic      scan_done;
  } dp_stat_t;

endpackage

// File: rtl/oal_dp.sv
// Datapath: entry memory, count, walk index and result registers.
`timescale 1ns / 1ps

module oal_dp #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  oal_pkg::cmd_t                cmd,
  output oal_pkg::dp_stat_t            st,
  input  logic [oal_pkg::ACT_W-1:0]    action,
  input  logic [oal_pkg::SLOT_W-1:0]   slot,
  input  logic signed [oal_pkg::ID_W-1:0] key_id,
  input  logic [oal_pkg::NAME_W-1:0]   entry_name,
  output logic [oal_pkg::STAT_W-1:0]   status,
  output logic [oal_pkg::NAME_W-1:0]   found_name,
  output logic [oal_pkg::CNT_W-1:0]    entry_count
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > oal_pkg::SLOT_W) ? CW : oal_pkg::SLOT_W;
  localparam int EW   = (CW > oal_pkg::CNT_W) ? CW : oal_pkg::CNT_W;

  logic [oal_pkg::ACT_W-1:0]  req_action;
  logic [oal_pkg::SLOT_W-1:0] req_slot;
  logic [oal_pkg::ID_W-1:0]   req_key;
  logic [oal_pkg::NAME_W-1:0] req_name;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] p;
  logic [CW-1:0] p_calc;
  logic [CW-1:0] rd_addr;
  logic          rd_en;

  logic [oal_pkg::ENT_W-1:0] mem [DEPTH];
  logic [oal_pkg::ENT_W-1:0] rd_data;
  logic                      mv_pend;
  logic [AW-1:0]             mv_addr;
  logic                      cmp_pend;
  logic                      hit;
  logic [oal_pkg::NAME_W-1:0] found;

  logic [CMPW-1:0]             slot_x;
  logic [CMPW-1:0]             count_x;
  logic [EW-1:0]               count_e;
  oal_pkg::op_class_t          cls;
  logic [oal_pkg::STAT_W-1:0]  err_code;
  logic [oal_pkg::STAT_W-1:0]  err_q;
  logic [oal_pkg::STAT_W-1:0]  result_code;

  // Request decode and error checks
  always_comb begin
    slot_x   = CMPW'(req_slot);
    count_x  = CMPW'(count);
    count_e  = EW'(count);
    cls      = oal_pkg::CLS_NONE;
    err_code = oal_pkg::ST_OK;
    p_calc   = '0;
    case (req_action)
      oal_pkg::ACT_INS_FRONT, oal_pkg::ACT_INS_BACK, oal_pkg::ACT_INS_AT: begin
        cls = oal_pkg::CLS_INS;
      end
      oal_pkg::ACT_DEL_FRONT, oal_pkg::ACT_DEL_BACK, oal_pkg::ACT_DEL_AT: begin
        cls = oal_pkg::CLS_DEL;
      end
      oal_pkg::ACT_FIND: begin
        cls = oal_pkg::CLS_FIND;
      end
      default: begin
        cls = oal_pkg::CLS_NONE;
      end
    endcase
    case (req_action)
      oal_pkg::ACT_INS_BACK: p_calc = count;
      oal_pkg::ACT_INS_AT,
      oal_pkg::ACT_DEL_AT:   p_calc = slot_x[CW-1:0];
      oal_pkg::ACT_DEL_BACK: p_calc = count - CW'(1);
      default:               p_calc = '0;
    endcase
    if (cls == oal_pkg::CLS_INS) begin
      if (count == CW'(DEPTH)) begin
        err_code = oal_pkg::ST_FULL;
      end else if (req_action == oal_pkg::ACT_INS_AT && slot_x > count_x) begin
        err_code = oal_pkg::ST_BADPOS;
      end
    end else if (cls == oal_pkg::CLS_DEL) begin
      if (count == '0) begin
        err_code = oal_pkg::ST_EMPTY;
      end else if (req_action == oal_pkg::ACT_DEL_AT && slot_x >= count_x) begin
        err_code = oal_pkg::ST_BADPOS;
      end
    end
    // err_q holds the check made before the count moved
    if (err_q != oal_pkg::ST_OK) begin
      result_code = err_q;
    end else if (cls == oal_pkg::CLS_FIND && !hit) begin
      result_code = oal_pkg::ST_NOTFOUND;
    end else begin
      result_code = oal_pkg::ST_OK;
    end
  end

  // Read address follows the direction of the walk
  always_comb begin
    rd_en = cmd.ins_step | cmd.del_step | cmd.scan_step;
    if (cmd.ins_step) begin
      rd_addr = idx - CW'(1);
    end else if (cmd.del_step) begin
      rd_addr = idx + CW'(1);
    end else begin
      rd_addr = idx;
    end
  end

  assign st.cls       = cls;
  assign st.err       = (err_code != oal_pkg::ST_OK);
  assign st.ins_done  = (idx == p);
  assign st.del_done  = ((CW+1)'(idx) + (CW+1)'(1)) >= (CW+1)'(count);
  assign st.scan_done = (idx == count);

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.put_new) begin
      mem[p[AW-1:0]] <= {req_key, req_name};
    end else if (mv_pend) begin
      mem[mv_addr] <= rd_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      mv_pend  <= 1'b0;
      cmp_pend <= 1'b0;
    end else begin
      mv_pend  <= cmd.ins_step | cmd.del_step;
      cmp_pend <= cmd.scan_step;
      if (cmd.put_new) begin
        count <= count + CW'(1);
      end else if (cmd.dec_count) begin
        count <= count - CW'(1);
      end
    end
  end

  // Request, walk and result registers
  always_ff @(posedge clk) begin
    mv_addr <= idx[AW-1:0];
    if (cmd.load_req) begin
      req_action <= action;
      req_slot   <= slot;
      req_key    <= key_id;
      req_name   <= entry_name;
      hit        <= 1'b0;
      found      <= '0;
    end else if (cmp_pend && rd_data[oal_pkg::ENT_W-1:oal_pkg::NAME_W] == req_key) begin
      hit   <= 1'b1;
      found <= rd_data[oal_pkg::NAME_W-1:0];
    end
    if (cmd.save_err) begin
      err_q <= err_code;
    end
    if (cmd.init_ins) begin
      idx <= count;
      p   <= p_calc;
    end else if (cmd.init_del) begin
      idx <= p_calc;
    end else if (cmd.init_scan) begin
      idx <= '0;
    end else if (cmd.ins_step) begin
      idx <= idx - CW'(1);
    end else if (cmd.del_step || cmd.scan_step) begin
      idx <= idx + CW'(1);
    end
    if (cmd.out_load) begin
      status      <= result_code;
      found_name  <= found;
      entry_count <= count_e[oal_pkg::CNT_W-1:0];
    end
  end

endmodule

// File: rtl/oal_ctrl.sv
// Controller: sequences one request at a time over the datapath.
`timescale 1ns / 1ps

module oal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  oal_pkg::dp_stat_t st,
  output oal_pkg::cmd_t     cmd
);

  oal_pkg::state_t state;
  oal_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      oal_pkg::S_IDLE: begin
        if (in_valid) state_next = oal_pkg::S_DECIDE;
      end
      oal_pkg::S_DECIDE: begin
        if (st.err) begin
          state_next = oal_pkg::S_FINISH;
        end else begin
          case (st.cls)
            oal_pkg::CLS_INS:  state_next = oal_pkg::S_INS_SHIFT;
            oal_pkg::CLS_DEL:  state_next = oal_pkg::S_DEL_SHIFT;
            oal_pkg::CLS_FIND: state_next = oal_pkg::S_SCAN;
            default:           state_next = oal_pkg::S_FINISH;
          endcase
        end
      end
      oal_pkg::S_INS_SHIFT: begin
        if (st.ins_done) state_next = oal_pkg::S_INS_PUT;
      end
      oal_pkg::S_INS_PUT: begin
        state_next = oal_pkg::S_FINISH;
      end
      oal_pkg::S_DEL_SHIFT: begin
        if (st.del_done) state_next = oal_pkg::S_FINISH;
      end
      oal_pkg::S_SCAN: begin
        if (st.scan_done) state_next = oal_pkg::S_FINISH;
      end
      oal_pkg::S_FINISH: begin
        if (out_free) state_next = oal_pkg::S_IDLE;
      end
      default: begin
        state_next = oal_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != oal_pkg::S_IDLE);
    case (state)
      oal_pkg::S_IDLE: begin
        cmd.load_req = in_valid;
      end
      oal_pkg::S_DECIDE: begin
        cmd.save_err = 1'b1;
        if (!st.err) begin
          cmd.init_ins  = (st.cls == oal_pkg::CLS_INS);
          cmd.init_del  = (st.cls == oal_pkg::CLS_DEL);
          cmd.init_scan = (st.cls == oal_pkg::CLS_FIND);
        end
      end
      oal_pkg::S_INS_SHIFT: begin
        cmd.ins_step = !st.ins_done;
      end
      oal_pkg::S_INS_PUT: begin
        cmd.put_new = 1'b1;
      end
      oal_pkg::S_DEL_SHIFT: begin
        cmd.del_step  = !st.del_done;
        cmd.dec_count = st.del_done;
      end
      oal_pkg::S_SCAN: begin
        cmd.scan_step = !st.scan_done;
      end
      oal_pkg::S_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oal_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ordered_array_list.sv
// Top level of the ordered array list: controller plus datapath.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH entries, each a 32-bit id and a 64-bit name.
// Input channel (in_valid/in_stall) takes one request beat: action, slot,
// key_id, entry_name. Output channel (out_valid/out_stall) returns one beat
// per request: status, found_name and the entry_count after the request.
// Requests are handled one at a time; in_stall is high from the accepting
// edge until the result is loaded into the output register.
// Each request walks the entry memory, with count the entries held and p
// the affected position: an insert shifts the entries from count - 1
// down to p up by one and then writes the new entry at p; a delete shifts
// the entries above p down by one and then lowers the count; a find
// compares every held entry and keeps the last match; errors and the
// unused action code skip the walk. The entry memory moves or compares
// one entry per cycle through its single registered read port.
// The output register holds a finished beat while out_stall is high; the
// next request may already be in progress and waits only at its last step.
// Reset (rst, synchronous) empties the list and drops any pending beat;
// the entry memory itself is not cleared, only entries below the count
// are ever read.

module ordered_array_list #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [oal_pkg::ACT_W-1:0]       action,
  input  logic [oal_pkg::SLOT_W-1:0]      slot,
  input  logic signed [oal_pkg::ID_W-1:0] key_id,
  input  logic [oal_pkg::NAME_W-1:0]      entry_name,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [oal_pkg::STAT_W-1:0]      status,
  output logic [oal_pkg::NAME_W-1:0]      found_name,
  output logic [oal_pkg::CNT_W-1:0]       entry_count
);

  oal_pkg::cmd_t     cmd;
  oal_pkg::dp_stat_t st;

  // Sequencer: one request in flight, steps the memory walk
  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Storage, shifting, search compare and the output register
  oal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .action      (action),
    .slot        (slot),
    .key_id      (key_id),
    .entry_name  (entry_name),
    .status      (status),
    .found_name  (found_name),
    .entry_count (entry_count)
  );

  `include "ordered_array_list_assert.svh"

  // A finished result never overwrites a beat still waiting at the output.
  `OAL_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)
  // Only one request in flight: an accepted beat closes the input.
  `OAL_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)
  // Loading the result register always presents a beat.
  `OAL_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid)
  // A nonzero name only comes back with a successful find.
  `OAL_ASSERT_NOW(a_name_ok, out_valid && found_name != '0, status == oal_pkg::ST_OK)

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the ordered array list: directed, full-list, stall and random tests.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off in the stall test
  localparam int IDLE_LIMIT  = 4000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;

  typedef logic [oal_pkg::ACT_W-1:0]  act_t;
  typedef logic [oal_pkg::SLOT_W-1:0] slot_t;

  // Action code 7 has no meaning; the block must leave the list alone.
  localparam act_t ACT_UNUSED = 3'd7;

  typedef struct {
    logic [oal_pkg::STAT_W-1:0] status;
    logic [oal_pkg::NAME_W-1:0] name;
    logic [oal_pkg::CNT_W-1:0]  count;
  } list_result_t;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [oal_pkg::ACT_W-1:0]        action;
  logic [oal_pkg::SLOT_W-1:0]       slot;
  logic signed [oal_pkg::ID_W-1:0]  key_id;
  logic [oal_pkg::NAME_W-1:0]       entry_name;
  logic                             out_valid;
  logic                             out_stall;
  logic [oal_pkg::STAT_W-1:0]       status;
  logic [oal_pkg::NAME_W-1:0]       found_name;
  logic [oal_pkg::CNT_W-1:0]        entry_count;

  // Shadow copy of the list, updated at each accepted request beat.
  int                               held_count;
  logic [oal_pkg::ID_W-1:0]         shadow_ids   [DEPTH];
  logic [oal_pkg::NAME_W-1:0]       shadow_names [DEPTH];
  list_result_t                     pending_results [$];

  int                               error_count;
  int                               idle_cycles;
  bit                               tx_no_gaps;
  bit                               rx_no_gaps;
  bit                               hold_req;
  bit                               hold_done;
  int                               stall_left;

  ordered_array_list #(.DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .slot        (slot),
    .key_id      (key_id),
    .entry_name  (entry_name),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_name  (found_name),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // List predictor: applies one request to the shadow list and returns
  // the beat the block should give for it.
  // ---------------------------------------------------------------------
  function automatic list_result_t apply_request(act_t act,
                                                 slot_t sl,
                                                 logic [oal_pkg::ID_W-1:0] key,
                                                 logic [oal_pkg::NAME_W-1:0] nm);
    list_result_t r;
    int pos;
    r.status = oal_pkg::ST_OK;
    r.name   = '0;
    pos      = -1;
    case (act)
      oal_pkg::ACT_INS_FRONT, oal_pkg::ACT_INS_BACK, oal_pkg::ACT_INS_AT: begin
        // full wins over a bad slot
        if (held_count >= DEPTH) r.status = oal_pkg::ST_FULL;
        else if (act == oal_pkg::ACT_INS_FRONT) pos = 0;
        else if (act == oal_pkg::ACT_INS_BACK) pos = held_count;
        else if (int'(sl) > held_count) r.status = oal_pkg::ST_BADPOS;
        else pos = int'(sl);
        if (pos >= 0) begin
          for (int i = held_count; i > pos; i--) begin
            shadow_ids[i]   = shadow_ids[i-1];
            shadow_names[i] = shadow_names[i-1];
          end
          shadow_ids[pos]   = key;
          shadow_names[pos] = nm;
          held_count++;
        end
      end
      oal_pkg::ACT_DEL_FRONT, oal_pkg::ACT_DEL_BACK, oal_pkg::ACT_DEL_AT: begin
        // empty wins over a bad slot
        if (held_count == 0) r.status = oal_pkg::ST_EMPTY;
        else if (act == oal_pkg::ACT_DEL_FRONT) pos = 0;
        else if (act == oal_pkg::ACT_DEL_BACK) pos = held_count - 1;
        else if (int'(sl) >= held_count) r.status = oal_pkg::ST_BADPOS;
        else pos = int'(sl);
        if (pos >= 0) begin
          for (int i = pos; i + 1 < held_count; i++) begin
            shadow_ids[i]   = shadow_ids[i+1];
            shadow_names[i] = shadow_names[i+1];
          end
          held_count--;
        end
      end
      oal_pkg::ACT_FIND: begin
        // last match (highest position) wins
        r.status = oal_pkg::ST_NOTFOUND;
        for (int i = 0; i < held_count; i++) begin
          if (shadow_ids[i] == key) begin
            r.name   = shadow_names[i];
            r.status = oal_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
    r.count = held_count[oal_pkg::CNT_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, a few medium, rare long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [oal_pkg::NAME_W-1:0] rand_name();
    return {$urandom, $urandom};
  endfunction

  // Small pool so finds hit and ids repeat; extremes included.
  function automatic logic [oal_pkg::ID_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4, 5: return $urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Request sender. Called at a rising edge; returns at the edge where
  // the beat is taken, after logging its predicted result.
  // ---------------------------------------------------------------------
  task automatic send_req(input act_t act, input slot_t sl,
                          input logic [oal_pkg::ID_W-1:0] key,
                          input logic [oal_pkg::NAME_W-1:0] nm);
    int gap;
    gap = (tx_no_gaps || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    slot       <= sl;
    key_id     <= key;
    entry_name <= nm;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_request(act, sl, key, nm));
  endtask

  // Sender pause: nothing offered until every predicted beat is back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One random request. ins_pct sets the insert share, so a phase can
  // push the list toward full or toward empty.
  task automatic rand_req(input int ins_pct);
    act_t                     act;
    slot_t                    sl;
    logic [oal_pkg::ID_W-1:0] key;
    int r;
    r   = $urandom_range(0, 99);
    key = pick_key();
    sl  = slot_t'($urandom_range(0, 31));
    if ($urandom_range(0, 19) == 0) begin
      // noise: any code, any slot
      act = act_t'($urandom_range(0, 7));
    end else if (r < ins_pct) begin
      act = act_t'($urandom_range(oal_pkg::ACT_INS_FRONT, oal_pkg::ACT_INS_AT));
      if ($urandom_range(0, 9) != 0) sl = slot_t'($urandom_range(0, held_count));
    end else if (r < 80) begin
      act = act_t'($urandom_range(oal_pkg::ACT_DEL_FRONT, oal_pkg::ACT_DEL_AT));
      if (held_count > 0 && $urandom_range(0, 9) != 0)
        sl = slot_t'($urandom_range(0, held_count - 1));
    end else begin
      act = oal_pkg::ACT_FIND;
      if (held_count > 0 && $urandom_range(0, 9) < 6)
        key = shadow_ids[$urandom_range(0, held_count - 1)];
    end
    send_req(act, sl, key, rand_name());
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty-list errors, the unused code, bad slots both sides, id extremes,
  // duplicate ids on find, and deletes at front, back and middle.
  task automatic test_directed_edges();
    send_req(oal_pkg::ACT_DEL_FRONT, 5'd0,  32'd0, '0);
    send_req(oal_pkg::ACT_DEL_BACK,  5'd0,  32'd0, '0);
    send_req(oal_pkg::ACT_DEL_AT,    5'd31, 32'd0, '0);
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'd0, '0);
    send_req(ACT_UNUSED,             5'd31, 32'hffff_ffff, '1);
    send_req(oal_pkg::ACT_INS_AT,    5'd1,  32'd9, rand_name());
    send_req(oal_pkg::ACT_INS_AT,    5'd0,  32'd100, rand_name());
    send_req(oal_pkg::ACT_INS_FRONT, 5'd0,  32'h8000_0000, '1);
    send_req(oal_pkg::ACT_INS_BACK,  5'd0,  32'h7fff_ffff, '0);
    send_req(oal_pkg::ACT_INS_AT,    5'd3,  32'd100, rand_name());
    send_req(oal_pkg::ACT_INS_AT,    5'd31, 32'd100, rand_name());
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'd100, '0);
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'h8000_0000, '0);
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'h7fff_ffff, '0);
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'd7, '0);
    send_req(oal_pkg::ACT_DEL_AT,    5'd4,  32'd0, '0);
    send_req(oal_pkg::ACT_DEL_AT,    5'd16, 32'd0, '0);
    send_req(oal_pkg::ACT_DEL_AT,    5'd1,  32'd0, '0);
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'd100, '0);
    send_req(oal_pkg::ACT_DEL_FRONT, 5'd0,  32'd0, '0);
    send_req(oal_pkg::ACT_DEL_BACK,  5'd0,  32'd0, '0);
    send_req(oal_pkg::ACT_DEL_AT,    5'd0,  32'd0, '0);
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'd100, '0);
    send_req(oal_pkg::ACT_INS_BACK,  5'd0,  32'hffff_ffff, rand_name());
    send_req(oal_pkg::ACT_FIND,      5'd0,  32'hffff_ffff, '0);
  endtask

  // Fill to DEPTH, hit every insert on a full list, then empty it again.
  task automatic test_full_list();
    act_t act;
    while (held_count < DEPTH) begin
      act = act_t'($urandom_range(oal_pkg::ACT_INS_FRONT, oal_pkg::ACT_INS_AT));
      send_req(act, slot_t'($urandom_range(0, held_count)), pick_key(), rand_name());
    end
    send_req(oal_pkg::ACT_INS_FRONT, 5'd0,  pick_key(), rand_name());
    send_req(oal_pkg::ACT_INS_BACK,  5'd0,  pick_key(), rand_name());
    send_req(oal_pkg::ACT_INS_AT,    5'd31, pick_key(), rand_name());
    send_req(oal_pkg::ACT_INS_AT,    5'd0,  pick_key(), rand_name());
    send_req(oal_pkg::ACT_FIND,      5'd0,  shadow_ids[0], '0);
    send_req(oal_pkg::ACT_FIND,      5'd0,  shadow_ids[DEPTH-1], '0);
    send_req(oal_pkg::ACT_DEL_AT,    5'd16, 32'd0, '0);
    send_req(oal_pkg::ACT_DEL_AT,    5'd15, 32'd0, '0);
    send_req(oal_pkg::ACT_INS_AT,    5'd15, pick_key(), rand_name());
    while (held_count > 0) begin
      act = act_t'($urandom_range(oal_pkg::ACT_DEL_FRONT, oal_pkg::ACT_DEL_AT));
      send_req(act, slot_t'($urandom_range(0, held_count - 1)), 32'd0, '0);
    end
    send_req(oal_pkg::ACT_DEL_AT, 5'd0, 32'd0, '0);
  endtask

  // Receiver holds off for HOLD_CYCLES while the sender keeps offering
  // back to back, so the block backs up and stalls its input.
  task automatic test_output_backpressure();
    tx_no_gaps = 1'b1;
    hold_req   = 1'b1;
    repeat (24) rand_req(50);
    tx_no_gaps = 1'b0;
    wait_for_results();
  endtask

  // Back-to-back beats on both sides.
  task automatic test_no_idle();
    tx_no_gaps = 1'b1;
    rx_no_gaps = 1'b1;
    repeat (100) rand_req($urandom_range(30, 50));
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  // Phases that lean toward filling or emptying the list.
  task automatic test_random_mix();
    int ins_pct;
    for (int phase = 0; phase < 10; phase++) begin
      ins_pct = (phase % 2 == 0) ? $urandom_range(45, 60) : $urandom_range(20, 35);
      repeat (100) rand_req(ins_pct);
      if ($urandom_range(0, 2) == 0) wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    error_count = 0;
    held_count  = 0;
    tx_no_gaps  = 1'b0;
    rx_no_gaps  = 1'b0;
    hold_req    = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    action     <= oal_pkg::ACT_FIND;
    slot       <= '0;
    key_id     <= '0;
    entry_name <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_full_list();
    test_output_backpressure();
    test_no_idle();
    test_random_mix();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver stall pattern; a hold request overrides it once for HOLD_CYCLES.
  initial begin
    out_stall <= 1'b0;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!rx_no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Result checker: each taken beat against the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", {61'd0, status}, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", {61'd0, status}, {61'd0, want.status});
        if (found_name !== want.name)
          report_mismatch("found_name", found_name, want.name);
        if (entry_count !== want.count)
          report_mismatch("entry_count", {59'd0, entry_count}, {59'd0, want.count});
      end
    end
  end

  // Watchdog: too long with no beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $realtime, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
